FILE: hdl/hashed_block_buffer_cache_defines.svh
// Assertion macros for the hashed block buffer cache.
// No dependencies.
`ifndef HASHED_BLOCK_BUFFER_CACHE_DEFINES_SVH
`define HASHED_BLOCK_BUFFER_CACHE_DEFINES_SVH
// implication checked every clock outside reset
`define HBBC_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("hbbc check failed");
// next-cycle implication checked every clock outside reset
`define HBBC_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("hbbc check failed");
`endif

FILE: hdl/hbbc_pkg.sv
// Types and codes shared by the hashed block buffer cache modules.
// No dependencies.
`timescale 1ns / 1ps
package hbbc_pkg;
  localparam logic [1:0] CMD_ACQUIRE = 2'd0;
  localparam logic [1:0] CMD_RELEASE = 2'd1;
  localparam logic [1:0] CMD_PIN     = 2'd2;
  localparam logic [1:0] CMD_UNPIN   = 2'd3;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_NOFREE   = 2'd1;
  localparam logic [1:0] ST_UNDER    = 2'd2;

  localparam logic [7:0] REFS_MAX    = 8'hff;

  // one tag store entry; bkt caches blk mod NUM_BUCKETS
  typedef struct packed {
    logic [7:0]  dev;
    logic [31:0] blk;
    logic [5:0]  bkt;
    logic [7:0]  refs;
    logic [31:0] stamp;
    logic        fill;
    logic [31:0] ord;
  } hbbc_entry_t;

  // controller -> datapath commands
  typedef struct packed {
    logic load;       // capture the incoming item
    logic scan_clr;   // reset scan index and picks
    logic scan_step;  // read one entry for the scan
    logic commit;     // apply update and build result
    logic init_wr;    // write one initial entry after reset
  } hbbc_cmd_t;

  // datapath -> controller status
  typedef struct packed {
    logic is_acquire;
    logic scan_last;
  } hbbc_stat_t;
endpackage

FILE: hdl/hbbc_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
module hbbc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

FILE: hdl/hbbc_ctrl.sv
// Controller state machine for the hashed block buffer cache.
// Depends on hbbc_pkg.
`timescale 1ns / 1ps
module hbbc_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  output logic               out_valid,
  input  logic               out_stall,
  input  hbbc_pkg::hbbc_stat_t stat,
  output hbbc_pkg::hbbc_cmd_t  cmd
);
  import hbbc_pkg::*;

  typedef enum logic [7:0] {
    S_INIT   = 8'b0000_0001,
    S_IDLE   = 8'b0000_0010,
    S_PREP   = 8'b0000_0100,
    S_SCAN   = 8'b0000_1000,
    S_LAST   = 8'b0001_0000,
    S_FETCH  = 8'b0010_0000,
    S_COMMIT = 8'b0100_0000,
    S_OUT    = 8'b1000_0000
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) state <= S_INIT;
    else state <= state_next;
  end

  assign in_stall  = (state != S_IDLE);
  assign out_valid = (state == S_OUT);

  always_comb begin
    state_next = state;
    cmd = '0;
    unique case (state)
      S_INIT: begin
        cmd.init_wr = 1'b1;
        if (stat.scan_last) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.load = 1'b1;
          cmd.scan_clr = 1'b1;
          state_next = S_PREP;
        end
      end
      S_PREP: begin
        state_next = stat.is_acquire ? S_SCAN : S_FETCH;
      end
      S_SCAN: begin
        cmd.scan_step = 1'b1;
        if (stat.scan_last) state_next = S_LAST;
      end
      S_LAST: begin
        state_next = S_FETCH;
      end
      S_FETCH: begin
        state_next = S_COMMIT;
      end
      S_COMMIT: begin
        cmd.commit = 1'b1;
        state_next = S_OUT;
      end
      S_OUT: begin
        if (!out_stall) state_next = S_IDLE;
      end
      default: state_next = S_INIT;
    endcase
  end
endmodule

FILE: hdl/hbbc_dp.sv
// Datapath: entry tag store in RAM, one-entry-per-cycle scan and update logic.
// Depends on hbbc_pkg and hbbc_ram.
`timescale 1ns / 1ps
module hbbc_dp #(
  parameter int NUM_BUCKETS        = 13,
  parameter int ENTRIES_PER_BUCKET = 3,
  parameter int NUM_ENTRIES        = 39
) (
  input  logic                 clk,
  input  logic                 rst,
  input  hbbc_pkg::hbbc_cmd_t  cmd_in,
  output hbbc_pkg::hbbc_stat_t stat,
  input  logic [1:0]           cmd,
  input  logic [7:0]           device_id,
  input  logic [31:0]          block_number,
  input  logic [5:0]           entry_select,
  input  logic [31:0]          now_tick,
  output logic [5:0]           entry_index,
  output logic                 was_hit,
  output logic                 need_fill,
  output logic [1:0]           status
);
  import hbbc_pkg::*;

  localparam int IW    = (NUM_ENTRIES > 1) ? $clog2(NUM_ENTRIES) : 1;
  localparam int EW    = $bits(hbbc_entry_t);
  // byte weights 256^k mod NUM_BUCKETS and a 24-bit reciprocal
  localparam int C1    = 256 % NUM_BUCKETS;
  localparam int C2    = (C1 * 256) % NUM_BUCKETS;
  localparam int C3    = (C2 * 256) % NUM_BUCKETS;
  localparam int RECIP = ((1 << 24) + NUM_BUCKETS - 1) / NUM_BUCKETS;

  logic [1:0]  r_cmd;
  logic [7:0]  r_dev;
  logic [31:0] r_blk;
  logic [5:0]  r_sel;
  logic [31:0] r_now;
  logic [15:0] r_s1, r_q;
  logic [5:0]  r_home;
  logic [15:0] s1_in, q_back;
  logic [47:0] q_prod;

  logic [IW:0] idx;
  logic [IW-1:0] ci, ev_i, pick, sidx, raddr, waddr;
  logic ev_v, we, sel_ok;
  logic hit_ok, home_ok, glob_ok;
  logic [IW-1:0] hit_p, home_p, glob_p;
  logic [31:0] hit_o, home_s, home_o, glob_s;
  logic [31:0] insert_counter, init_blk, init_ord;
  logic [5:0]  init_bkt;
  logic [EW-1:0] ram_q;
  hbbc_entry_t rd, wr_e;
  logic m_hit, m_free, m_home;

  assign ci = idx[IW-1:0];
  assign stat.is_acquire = (r_cmd == CMD_ACQUIRE);
  assign stat.scan_last  = (idx == (IW+1)'(NUM_ENTRIES - 1));

  // home bucket: fold bytes, then reciprocal multiply over two registered steps
  assign s1_in = 16'(block_number[7:0]) + 16'(block_number[15:8]) * 16'(C1)
               + 16'(block_number[23:16]) * 16'(C2) + 16'(block_number[31:24]) * 16'(C3);
  assign q_prod = 48'(r_s1) * 48'(RECIP);
  assign q_back = r_q * 16'(NUM_BUCKETS);

  assign rd = ram_q;
  assign m_hit  = ev_v && (rd.dev == r_dev) && (rd.blk == r_blk);
  assign m_free = ev_v && (rd.refs == 8'd0);
  assign m_home = m_free && (rd.bkt == r_home);

  assign pick   = hit_ok ? hit_p : (home_ok ? home_p : glob_p);
  assign sidx   = r_sel[IW-1:0];
  assign sel_ok = (r_sel < 6'(NUM_ENTRIES));
  assign raddr  = cmd_in.scan_step ? ci : (stat.is_acquire ? pick : sidx);

  always_comb begin
    wr_e  = rd;
    we    = 1'b0;
    waddr = sidx;
    if (cmd_in.init_wr) begin
      we = 1'b1;
      waddr = ci;
      wr_e = '0;
      wr_e.blk = init_blk;
      wr_e.bkt = init_bkt;
      wr_e.ord = init_ord;
    end else if (cmd_in.commit) begin
      if (r_cmd == CMD_ACQUIRE) begin
        waddr = pick;
        if (hit_ok) begin
          we = 1'b1;
          wr_e.fill = 1'b1;
          if (rd.refs != REFS_MAX) wr_e.refs = rd.refs + 8'd1;
        end else if (home_ok || glob_ok) begin
          we = 1'b1;
          wr_e.dev  = r_dev;
          wr_e.blk  = r_blk;
          wr_e.bkt  = r_home;
          wr_e.refs = 8'd1;
          wr_e.fill = 1'b1;
          if (!home_ok) wr_e.ord = insert_counter;
        end
      end else if (sel_ok) begin
        we = 1'b1;
        if (r_cmd == CMD_PIN) begin
          if (rd.refs != REFS_MAX) wr_e.refs = rd.refs + 8'd1;
        end else if (rd.refs != 8'd0) begin
          wr_e.refs = rd.refs - 8'd1;
          if (r_cmd == CMD_RELEASE && rd.refs == 8'd1) wr_e.stamp = r_now;
        end
      end
    end
  end

  hbbc_ram #(
    .WIDTH(EW), .DEPTH(NUM_ENTRIES)
  ) u_ram (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wr_e), .raddr(raddr), .rdata(ram_q)
  );

  always_ff @(posedge clk) begin
    if (cmd_in.load) begin
      r_cmd  <= cmd;
      r_dev  <= device_id;
      r_blk  <= block_number;
      r_sel  <= entry_select;
      r_now  <= now_tick;
      r_s1   <= s1_in;
    end
    r_q    <= q_prod[39:24];
    r_home <= 6'(r_s1 - q_back);
    if (cmd_in.scan_clr) begin
      hit_ok <= 1'b0; home_ok <= 1'b0; glob_ok <= 1'b0;
    end else if (ev_v) begin
      if (m_hit && (!hit_ok || rd.ord > hit_o)) begin
        hit_ok <= 1'b1; hit_p <= ev_i; hit_o <= rd.ord;
      end
      if (m_home && (!home_ok || rd.stamp < home_s ||
          (rd.stamp == home_s && rd.ord > home_o))) begin
        home_ok <= 1'b1; home_p <= ev_i; home_s <= rd.stamp; home_o <= rd.ord;
      end
      if (m_free && (!glob_ok || rd.stamp < glob_s)) begin
        glob_ok <= 1'b1; glob_p <= ev_i; glob_s <= rd.stamp;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      idx <= '0;
      ev_v <= 1'b0;
      init_blk <= '0;
      init_ord <= '0;
      init_bkt <= '0;
      insert_counter <= 32'(ENTRIES_PER_BUCKET);
    end else begin
      ev_v <= cmd_in.scan_step;
      ev_i <= ci;
      if (cmd_in.scan_clr) idx <= '0;
      else if (cmd_in.scan_step || cmd_in.init_wr) idx <= idx + 1'b1;
      if (cmd_in.init_wr) begin
        if (init_ord == 32'(ENTRIES_PER_BUCKET - 1)) begin
          init_ord <= '0;
          init_blk <= init_blk + 32'd1;
          init_bkt <= (init_bkt == 6'(NUM_BUCKETS - 1)) ? 6'd0 : init_bkt + 6'd1;
        end else begin
          init_ord <= init_ord + 32'd1;
        end
      end
      if (cmd_in.commit) begin
        was_hit <= 1'b0; need_fill <= 1'b0; status <= ST_OK;
        entry_index <= r_sel;
        if (r_cmd == CMD_ACQUIRE) begin
          if (hit_ok) begin
            was_hit <= 1'b1;
            need_fill <= !rd.fill;
            entry_index <= 6'(pick);
          end else if (home_ok || glob_ok) begin
            entry_index <= 6'(pick);
            need_fill <= 1'b1;
            if (!home_ok) insert_counter <= insert_counter + 32'd1;
          end else begin
            entry_index <= '0;
            status <= ST_NOFREE;
          end
        end else if (sel_ok && r_cmd != CMD_PIN && rd.refs == 8'd0) begin
          status <= ST_UNDER;
        end
      end
    end
  end
endmodule

FILE: hdl/hashed_block_buffer_cache.sv
// Top level of the hashed block buffer cache tag manager.
// Depends on hbbc_pkg, hbbc_ctrl, hbbc_dp and the defines header.
//
// Usage: one input channel (valid/stall) carries cmd, device_id,
// block_number, entry_select and now_tick; one output channel
// (valid/stall) returns entry_index, was_hit, need_fill and status.
// Exactly one result per item, in order.
// An acquire computes the home bucket, runs a tag scan that reads one
// RAM entry per cycle, then reads and updates the picked entry. Release,
// pin and unpin skip the scan. One item is in flight at a time; the next
// item is accepted the cycle after the result is taken.
// A stalled result holds steady; the input stalls until it is taken.
// Reset (rst, synchronous) starts a pass that writes every entry's initial
// tag, count zero and stamp zero, with the input stalled; the insertion
// counter restarts at ENTRIES_PER_BUCKET.
`timescale 1ns / 1ps
`include "hashed_block_buffer_cache_defines.svh"
module hashed_block_buffer_cache #(
  parameter int NUM_BUCKETS        = 13,
  parameter int ENTRIES_PER_BUCKET = 3,
  parameter int NUM_ENTRIES        = 39
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  cmd,
  input  logic [7:0]  device_id,
  input  logic [31:0] block_number,
  input  logic [5:0]  entry_select,
  input  logic [31:0] now_tick,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [5:0]  entry_index,
  output logic        was_hit,
  output logic        need_fill,
  output logic [1:0]  status
);
  import hbbc_pkg::*;

  hbbc_cmd_t  ctl;
  hbbc_stat_t st;

  hbbc_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall),
    .out_valid(out_valid), .out_stall(out_stall), .stat(st), .cmd(ctl)
  );

  hbbc_dp #(
    .NUM_BUCKETS(NUM_BUCKETS), .ENTRIES_PER_BUCKET(ENTRIES_PER_BUCKET),
    .NUM_ENTRIES(NUM_ENTRIES)
  ) u_dp (
    .clk(clk), .rst(rst), .cmd_in(ctl), .stat(st),
    .cmd(cmd), .device_id(device_id), .block_number(block_number),
    .entry_select(entry_select), .now_tick(now_tick),
    .entry_index(entry_index), .was_hit(was_hit), .need_fill(need_fill),
    .status(status)
  );

  `HBBC_ASSERT_IMP(a_no_accept_busy, out_valid, in_stall)
  `HBBC_ASSERT_IMP(a_hit_ok, out_valid && was_hit, status == ST_OK)
  `HBBC_ASSERT_NEXT(a_accept_no_out, in_valid && !in_stall, !out_valid)
endmodule
